// ===== rtl/lbmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbmt_pkg;

    localparam int MAX_BEAMS_DEF    = 2048;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int BEAM_W   = 11;
    localparam int RANGE_W  = 16;
    localparam int POS_W    = 24;
    localparam int QUAT_W   = 16;
    localparam int ANGLE_W  = 16;
    localparam int REG_W    = 16;
    localparam int REG_IDX_W = 3;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 64;

    localparam int CW      = 36;
    localparam int MA_W    = 34;
    localparam int MB_W    = 20;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int ACC_W   = 56;
    localparam int RND_W   = ACC_W - 30;
    localparam int VEC_W   = 20;
    localparam int ANGLE_IDX_W = 5;

    localparam logic signed [CW-1:0] GAIN_Q30     = 36'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30      = 36'sd1073741824;
    localparam logic signed [CW-1:0] QUARTER_TURN = 36'sd1073741824;
    localparam logic signed [CW-1:0] HEADING_HALF = 36'sd32768;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 56'sd536870912;

    localparam logic KIND_POSE = 1'b0;
    localparam logic KIND_BEAM = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FIRST_BEAM_ANGLE = 3'd0,
        REG_BEAM_ANGLE_STEP  = 3'd1,
        REG_MIN_VALID_RANGE  = 3'd2,
        REG_MAX_VALID_RANGE  = 3'd3,
        REG_MOUNT_OFFSET_X   = 3'd4,
        REG_MOUNT_OFFSET_Y   = 3'd5,
        REG_MOUNT_YAW        = 3'd6
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POSE_M0,
        ST_POSE_M1,
        ST_POSE_M2,
        ST_POSE_M3,
        ST_POSE_M4,
        ST_POSE_M5,
        ST_VEC_PRE,
        ST_VEC,
        ST_VEC_END,
        ST_BEAM_M0,
        ST_ROT_LOAD,
        ST_ROT,
        ST_ROT_END,
        ST_LASER_M0,
        ST_LASER_M1,
        ST_LASER_M2,
        ST_XF_M0,
        ST_XF_M1,
        ST_XF_M2,
        ST_XF_M3,
        ST_XF_M4,
        ST_XF_M5,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PASS_BEAM,
        PASS_MOUNT,
        PASS_EGO
    } pass_t;

    function automatic logic [31:0] atan_entry(input logic [ANGLE_IDX_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [RND_W-1:0] round_q30(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + ROUND_HALF;
        return t[ACC_W-1:30];
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1]) begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lidar_beam_to_map_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Converts lidar beams to map points. A pose transaction (tuser 0) stores the ego position
// and derives the heading from the quaternion by a vectoring CORDIC; it gives no result. A
// beam transaction (tuser 1) is range checked and passed through three rotation CORDIC runs
// (beam angle, mount yaw, ego heading) on one shared CORDIC and one shared multiplier; an
// invalid beam skips them and gives a result flagged invalid with zero coordinates, and a
// beam before any pose is dropped without a result. The output register lets the next
// transaction in while a result waits; the block stalls only if a second result is due
// before the first has been taken.

module lidar_beam_to_map_transform
    import lbmt_pkg::*;
#(
    parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      cfg_we,
    input  wire  [REG_IDX_W-1:0]     cfg_index,
    input  wire  [REG_W-1:0]         cfg_wdata,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // beam_number, range_mm, range_finite, pose_x_mm, pose_y_mm, quat_x, quat_y, quat_z,
    // quat_w, zero padding
    input  wire  [S_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire                      s_tuser,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // point_x_mm, point_y_mm, point_beam, zero padding
    output logic [M_TDATA_W-1:0]     m_tdata,
    // point_valid
    output logic                     m_tuser
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    state_t state_reg, state_next;
    pass_t  pass_reg, pass_next;

    logic [ANGLE_W-1:0]        cfg_first_reg;
    logic [REG_W-1:0]          cfg_step_reg;
    logic [RANGE_W-1:0]        cfg_min_reg;
    logic [RANGE_W-1:0]        cfg_max_reg;
    logic signed [REG_W-1:0]   cfg_off_x_reg;
    logic signed [REG_W-1:0]   cfg_off_y_reg;
    logic [ANGLE_W-1:0]        cfg_yaw_reg;

    logic signed [POS_W-1:0]   ego_x_reg, ego_x_next;
    logic signed [POS_W-1:0]   ego_y_reg, ego_y_next;
    logic [ANGLE_W-1:0]        heading_reg, heading_next;
    logic                      pose_known_reg, pose_known_next;

    logic [BEAM_W-1:0]         beam_reg, beam_next;
    logic [RANGE_W-1:0]        range_reg, range_next;
    logic signed [QUAT_W-1:0]  qx_reg, qx_next, qy_reg, qy_next;
    logic signed [QUAT_W-1:0]  qz_reg, qz_next, qw_reg, qw_next;

    logic signed [CW-1:0]      cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      flip_reg, flip_next;
    logic signed [MA_W-1:0]    cos_reg, cos_next, sin_reg, sin_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [VEC_W-1:0]   vx_reg, vx_next, vy_reg, vy_next, tx_reg, tx_next;

    logic signed [POS_W-1:0]   res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                      res_valid_reg, res_valid_next;

    logic signed [POS_W-1:0]   out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [BEAM_W-1:0]         out_beam_reg, out_beam_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    logic signed [CW-1:0]      dx, dy, atan_v;
    logic                      last_step;
    logic signed [VEC_W-1:0]   rnd_acc, rnd_prod;
    logic [ANGLE_W-1:0]        rot_ang;
    logic signed [ANGLE_W:0]   ang_ext, ang_fold;
    logic                      ang_flip;

    logic [BEAM_W-1:0]         in_beam;
    logic [RANGE_W-1:0]        in_range;
    logic                      in_finite;
    logic                      in_valid;
    logic signed [POS_W:0]     sum_x, sum_y;

    assign in_beam   = s_tdata[10:0];
    assign in_range  = s_tdata[26:11];
    assign in_finite = s_tdata[27];
    assign in_valid  = in_finite && (in_range >= cfg_min_reg) && (in_range <= cfg_max_reg)
                       && (17'(in_beam) < 17'(MAX_BEAMS));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_beam_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_valid_reg;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = cos_reg;
        mul_b = vx_reg;
        case (state_reg)
            ST_POSE_M0: begin
                mul_a = MA_W'(qw_reg);
                mul_b = MB_W'(qz_reg);
            end
            ST_POSE_M1: begin
                mul_a = MA_W'(qx_reg);
                mul_b = MB_W'(qy_reg);
            end
            ST_POSE_M2: begin
                mul_a = MA_W'(qy_reg);
                mul_b = MB_W'(qy_reg);
            end
            ST_POSE_M3: begin
                mul_a = MA_W'(qz_reg);
                mul_b = MB_W'(qz_reg);
            end
            ST_BEAM_M0: begin
                mul_a = MA_W'($signed({1'b0, beam_reg}));
                mul_b = MB_W'($signed(cfg_step_reg));
            end
            ST_LASER_M0: begin
                mul_a = cos_reg;
                mul_b = MB_W'($signed({1'b0, range_reg}));
            end
            ST_LASER_M1: begin
                mul_a = sin_reg;
                mul_b = MB_W'($signed({1'b0, range_reg}));
            end
            ST_XF_M0: begin
                mul_a = cos_reg;
                mul_b = vx_reg;
            end
            ST_XF_M1: begin
                mul_a = sin_reg;
                mul_b = vy_reg;
            end
            ST_XF_M2: begin
                mul_a = sin_reg;
                mul_b = vx_reg;
            end
            ST_XF_M3: begin
                mul_a = cos_reg;
                mul_b = vy_reg;
            end
            default: begin
                mul_a = cos_reg;
                mul_b = vx_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dx        = cy_reg >>> step_reg;
    assign dy        = cx_reg >>> step_reg;
    assign atan_v    = $signed(CW'(atan_entry(ANGLE_IDX_W'(step_reg))));
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));
    assign rnd_acc   = VEC_W'(round_q30(acc_reg));
    assign rnd_prod  = VEC_W'(round_q30(ACC_W'(prod_reg)));
    assign sum_x     = (POS_W + 1)'(ego_x_reg) + (POS_W + 1)'(tx_reg);
    assign sum_y     = (POS_W + 1)'(ego_y_reg) + (POS_W + 1)'(rnd_acc);

    // Angle for the next rotation run, folded into the quarter turns either side of zero.
    always_comb begin
        case (pass_reg)
            PASS_BEAM:  rot_ang = cfg_first_reg + prod_reg[ANGLE_W-1:0];
            PASS_MOUNT: rot_ang = cfg_yaw_reg;
            PASS_EGO:   rot_ang = heading_reg;
            default:    rot_ang = heading_reg;
        endcase
        ang_ext  = {rot_ang[ANGLE_W-1], rot_ang};
        ang_fold = ang_ext;
        ang_flip = 1'b0;
        if (ang_ext > 17'sd16384) begin
            ang_fold = ang_ext - 17'sd32768;
            ang_flip = 1'b1;
        end else if (ang_ext < -17'sd16384) begin
            ang_fold = ang_ext + 17'sd32768;
            ang_flip = 1'b1;
        end
    end

    always_comb begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        ego_x_next      = ego_x_reg;
        ego_y_next      = ego_y_reg;
        heading_next    = heading_reg;
        pose_known_next = pose_known_reg;
        beam_next       = beam_reg;
        range_next      = range_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qz_next         = qz_reg;
        qw_next         = qw_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        step_next       = step_reg;
        flip_next       = flip_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        acc_next        = acc_reg;
        vx_next         = vx_reg;
        vy_next         = vy_reg;
        tx_next         = tx_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_valid_next  = res_valid_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_beam_next   = out_beam_reg;
        out_valid_next  = out_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    beam_next  = in_beam;
                    range_next = in_range;
                    qx_next    = s_tdata[91:76];
                    qy_next    = s_tdata[107:92];
                    qz_next    = s_tdata[123:108];
                    qw_next    = s_tdata[139:124];
                    if (s_tuser == KIND_POSE) begin
                        ego_x_next = s_tdata[51:28];
                        ego_y_next = s_tdata[75:52];
                        state_next = ST_POSE_M0;
                    end else if (pose_known_reg) begin
                        pass_next = PASS_BEAM;
                        if (in_valid) begin
                            state_next = ST_BEAM_M0;
                        end else begin
                            res_x_next     = '0;
                            res_y_next     = '0;
                            res_valid_next = 1'b0;
                            state_next     = ST_OUT;
                        end
                    end
                end
            end
            ST_POSE_M0: begin
                state_next = ST_POSE_M1;
            end
            ST_POSE_M1: begin
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_POSE_M2;
            end
            ST_POSE_M2: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_POSE_M3;
            end
            ST_POSE_M3: begin
                cy_next    = CW'(acc_reg) <<< 1;
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_POSE_M4;
            end
            ST_POSE_M4: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_POSE_M5;
            end
            ST_POSE_M5: begin
                cx_next    = ONE_Q30 - (CW'(acc_reg) <<< 1);
                state_next = ST_VEC_PRE;
            end
            ST_VEC_PRE: begin
                step_next = '0;
                cz_next   = '0;
                if (cx_reg == '0 && cy_reg == '0) begin
                    heading_next    = '0;
                    pose_known_next = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    if (cx_reg[CW-1]) begin
                        if (!cy_reg[CW-1]) begin
                            cx_next = cy_reg;
                            cy_next = -cx_reg;
                            cz_next = QUARTER_TURN;
                        end else begin
                            cx_next = -cy_reg;
                            cy_next = cx_reg;
                            cz_next = -QUARTER_TURN;
                        end
                    end
                    state_next = ST_VEC;
                end
            end
            ST_VEC: begin
                if (!cy_reg[CW-1] && cy_reg != '0) begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_v;
                end else begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_v;
                end
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_VEC_END;
                end
            end
            ST_VEC_END: begin
                heading_next    = ANGLE_W'((cz_reg + HEADING_HALF) >>> 16);
                pose_known_next = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_BEAM_M0: begin
                state_next = ST_ROT_LOAD;
            end
            ST_ROT_LOAD: begin
                cx_next    = GAIN_Q30;
                cy_next    = '0;
                cz_next    = CW'(ang_fold) <<< 16;
                flip_next  = ang_flip;
                step_next  = '0;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                if (!cz_reg[CW-1]) begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_v;
                end else begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_v;
                end
                step_next = step_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_ROT_END;
                end
            end
            ST_ROT_END: begin
                cos_next = flip_reg ? MA_W'(-cx_reg) : MA_W'(cx_reg);
                sin_next = flip_reg ? MA_W'(-cy_reg) : MA_W'(cy_reg);
                if (pass_reg == PASS_BEAM) begin
                    state_next = ST_LASER_M0;
                end else begin
                    state_next = ST_XF_M0;
                end
            end
            ST_LASER_M0: begin
                state_next = ST_LASER_M1;
            end
            ST_LASER_M1: begin
                vx_next    = rnd_prod;
                state_next = ST_LASER_M2;
            end
            ST_LASER_M2: begin
                vy_next    = rnd_prod;
                pass_next  = PASS_MOUNT;
                state_next = ST_ROT_LOAD;
            end
            ST_XF_M0: begin
                state_next = ST_XF_M1;
            end
            ST_XF_M1: begin
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_XF_M2;
            end
            ST_XF_M2: begin
                acc_next   = acc_reg - ACC_W'(prod_reg);
                state_next = ST_XF_M3;
            end
            ST_XF_M3: begin
                tx_next    = rnd_acc;
                acc_next   = ACC_W'(prod_reg);
                state_next = ST_XF_M4;
            end
            ST_XF_M4: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_XF_M5;
            end
            ST_XF_M5: begin
                if (pass_reg == PASS_MOUNT) begin
                    vx_next    = VEC_W'(cfg_off_x_reg) + tx_reg;
                    vy_next    = VEC_W'(cfg_off_y_reg) + rnd_acc;
                    pass_next  = PASS_EGO;
                    state_next = ST_ROT_LOAD;
                end else begin
                    res_x_next     = sat24(sum_x);
                    res_y_next     = sat24(sum_y);
                    res_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_beam_next  = beam_reg;
                    out_valid_next = res_valid_reg;
                    m_tvalid_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pass_reg       <= PASS_BEAM;
            m_tvalid_reg   <= 1'b0;
            pose_known_reg <= 1'b0;
            ego_x_reg      <= '0;
            ego_y_reg      <= '0;
            heading_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            m_tvalid_reg   <= m_tvalid_next;
            pose_known_reg <= pose_known_next;
            ego_x_reg      <= ego_x_next;
            ego_y_reg      <= ego_y_next;
            heading_reg    <= heading_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_first_reg <= '0;
            cfg_step_reg  <= '0;
            cfg_min_reg   <= '0;
            cfg_max_reg   <= '1;
            cfg_off_x_reg <= '0;
            cfg_off_y_reg <= '0;
            cfg_yaw_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FIRST_BEAM_ANGLE: cfg_first_reg <= cfg_wdata;
                REG_BEAM_ANGLE_STEP:  cfg_step_reg  <= cfg_wdata;
                REG_MIN_VALID_RANGE:  cfg_min_reg   <= cfg_wdata;
                REG_MAX_VALID_RANGE:  cfg_max_reg   <= cfg_wdata;
                REG_MOUNT_OFFSET_X:   cfg_off_x_reg <= cfg_wdata;
                REG_MOUNT_OFFSET_Y:   cfg_off_y_reg <= cfg_wdata;
                REG_MOUNT_YAW:        cfg_yaw_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        beam_next_hold: begin
        end
        beam_reg      <= beam_next;
        range_reg     <= range_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qz_reg        <= qz_next;
        qw_reg        <= qw_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        step_reg      <= step_next;
        flip_reg      <= flip_next;
        cos_reg       <= cos_next;
        sin_reg       <= sin_next;
        prod_reg      <= mul_p;
        acc_reg       <= acc_next;
        vx_reg        <= vx_next;
        vy_reg        <= vy_next;
        tx_reg        <= tx_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_valid_reg <= res_valid_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_beam_reg  <= out_beam_next;
        out_valid_reg <= out_valid_next;
    end

    a_result_needs_pose: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pose_known_reg)
        else $error("Result presented before any pose was stored.");

    a_invalid_point_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[47:0] == 48'd0))
        else $error("Invalid point carries non-zero coordinates.");

    a_early_beam_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_BEAM && !pose_known_reg)
        |=> (state_reg == ST_IDLE && !$rose(m_tvalid_reg)))
        else $error("Beam before any pose did not leave the block idle.");

    a_pose_starts_sequence: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_POSE) |=> (state_reg == ST_POSE_M0))
        else $error("Pose transaction did not start the heading sequence.");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("Pending result overwritten while output stalled.");

endmodule

`default_nettype wire
